FILE: design/cpcr_pkg.sv
package cpcr_pkg;

	localparam int VALUE_WIDTH_DEF = 24;
	localparam int FRAC_BITS_DEF = 8;

	localparam logic [1:0] REQ_ELASTIC = 2'd0;
	localparam logic [1:0] REQ_RESTIT = 2'd1;
	localparam logic [1:0] REQ_INELASTIC = 2'd2;

	localparam int CFG_IW = 2;
	localparam logic [CFG_IW-1:0] CFG_RESTITUTION = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_RADIUS = 2'd1;

	localparam logic [8:0] RESTIT_RESET = 9'd128;
	localparam logic [15:0] RADIUS_RESET = 16'd2560;
	localparam logic [8:0] E_ONE = 9'd256;

	localparam int NORM_SH = 14;
	localparam int SQRT_STEPS = 16;
	localparam int NDIV_STEPS = 15;
	localparam int STEPS_PER_STAGE = 2;

endpackage

FILE: design/circle_pair_collision_resolver.sv
// Channel   Direction  Handshake                Payload
// req       in         req_valid / req_stall    req_type, positions, velocities, masses
// rsp       out        rsp_valid / rsp_stall    new velocities, stuck, applied, touching
// cfg       in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One item enters per cycle while req_stall is low. The pipeline depth is set by the
// two-bit-per-stage square root and the two long dividers for the normal and the impulse.
// Reset clears the valid bits of all stages and loads the register defaults.
// A stall on rsp holds the run of full stages that reaches the output; stages behind an empty stage keep moving.
module circle_pair_collision_resolver import cpcr_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [1:0]                    req_type,
	input  logic signed [VALUE_WIDTH-1:0] pos_ax,
	input  logic signed [VALUE_WIDTH-1:0] pos_ay,
	input  logic signed [VALUE_WIDTH-1:0] vel_ax,
	input  logic signed [VALUE_WIDTH-1:0] vel_ay,
	input  logic signed [VALUE_WIDTH-1:0] pos_bx,
	input  logic signed [VALUE_WIDTH-1:0] pos_by,
	input  logic signed [VALUE_WIDTH-1:0] vel_bx,
	input  logic signed [VALUE_WIDTH-1:0] vel_by,
	input  logic [15:0]                   mass_a,
	input  logic [15:0]                   mass_b,
	input  logic                          both_active,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic signed [VALUE_WIDTH-1:0] new_vel_ax,
	output logic signed [VALUE_WIDTH-1:0] new_vel_ay,
	output logic signed [VALUE_WIDTH-1:0] new_vel_bx,
	output logic signed [VALUE_WIDTH-1:0] new_vel_by,
	output logic                          stuck,
	output logic                          applied,
	output logic                          touching,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IW-1:0]             cfg_index,
	input  logic [15:0]                   cfg_data
);

	localparam int W = VALUE_WIDTH;
	localparam int F = FRAC_BITS;
	localparam int NW = (W > 15) ? W : 15;
	localparam int SHW = $clog2(NW);
	localparam int LSH = (F >= 8) ? F - 8 : 0;
	localparam int RSH = (F < 8) ? 8 - F : 0;
	localparam int RW = 17 + LSH;
	localparam int CW = (W > RW) ? W : RW;
	localparam int QB = W + 2;
	localparam int NUMW = W + 19;
	localparam int SPS = STEPS_PER_STAGE;
	localparam int SQ_ST = (SQRT_STEPS + SPS - 1) / SPS;
	localparam int ND_ST = (NDIV_STEPS + SPS - 1) / SPS;
	localparam int JD_ST = (QB + SPS - 1) / SPS;

	localparam int S_IN = 1;
	localparam int S_NORM = 2;
	localparam int S_SQR = 3;
	localparam int SQ0 = 4;
	localparam int ND0 = SQ0 + SQ_ST;
	localparam int S_NSIGN = ND0 + ND_ST;
	localparam int S_PROD = S_NSIGN + 1;
	localparam int S_P = S_PROD + 1;
	localparam int S_X = S_P + 1;
	localparam int S_NUM = S_X + 1;
	localparam int S_SEL = S_NUM + 1;
	localparam int JD0 = S_SEL + 1;
	localparam int S_JP = JD0 + JD_ST;
	localparam int S_UPD = S_JP + 1;
	localparam int NS = S_UPD + 1;

	typedef struct packed {
		logic [1:0]            typ;
		logic                  act;
		logic signed [W-1:0]   vax;
		logic signed [W-1:0]   vay;
		logic signed [W-1:0]   vbx;
		logic signed [W-1:0]   vby;
		logic [15:0]           ma;
		logic [15:0]           mb;
		logic [16:0]           msum;
		logic [9:0]            k;
		logic                  inel;
		logic                  imp;
		logic [W-1:0]          mx;
		logic [W-1:0]          my;
		logic                  dxn;
		logic                  dyn;
		logic signed [W:0]     dvx;
		logic signed [W:0]     dvy;
		logic signed [W+16:0]  iax;
		logic signed [W+16:0]  ibx;
		logic signed [W+16:0]  iay;
		logic signed [W+16:0]  iby;
		logic signed [W+17:0]  isx;
		logic signed [W+17:0]  isy;
		logic [W+17:0]         ima;
		logic [W+17:0]         imb;
		logic                  sgx;
		logic                  sgy;
		logic                  tlt;
		logic [2*RW-1:0]       tsx;
		logic [2*RW-1:0]       tsy;
		logic                  touch;
		logic [14:0]           nxm;
		logic [14:0]           nym;
		logic [31:0]           sqx;
		logic [18:0]           srem;
		logic [15:0]           root;
		logic [16:0]           drx;
		logic [16:0]           dry;
		logic [14:0]           qx;
		logic [14:0]           qy;
		logic signed [15:0]    nx;
		logic signed [15:0]    ny;
		logic signed [W+16:0]  px;
		logic signed [W+16:0]  py;
		logic                  pos;
		logic [W:0]            vr;
		logic [W+10:0]         xk;
		logic [W+26:0]         na;
		logic [W+26:0]         nb;
		logic [NUMW-1:0]       da;
		logic [NUMW-1:0]       db;
		logic [17:0]           ra;
		logic [17:0]           rb;
		logic [QB-1:0]         qa;
		logic [QB-1:0]         qb;
		logic signed [W+2:0]   fx;
		logic signed [W+2:0]   fy;
		logic signed [W+18:0]  pax;
		logic signed [W+18:0]  pay;
		logic signed [W+18:0]  pbx;
		logic signed [W+18:0]  pby;
		logic signed [W+5:0]   rax;
		logic signed [W+5:0]   ray;
		logic signed [W+5:0]   rbx;
		logic signed [W+5:0]   rby;
		logic                  appl;
		logic                  stk;
		logic signed [W-1:0]   oax;
		logic signed [W-1:0]   oay;
		logic signed [W-1:0]   obx;
		logic signed [W-1:0]   oby;
	} item_t;

	function automatic logic signed [W+4:0] trunc_q14(input logic signed [W+18:0] v);
		logic signed [W+18:0] t;
		t = v[W+18] ? v + 16383 : v;
		return (W+5)'(t >>> NORM_SH);
	endfunction

	function automatic logic signed [W-1:0] sat_v(input logic signed [W+5:0] v);
		logic signed [W-1:0] r;
		if (v[W+5:W-1] == '0 || v[W+5:W-1] == '1) begin
			r = v[W-1:0];
		end else if (v[W+5]) begin
			r = {1'b1, {(W-1){1'b0}}};
		end else begin
			r = {1'b0, {(W-1){1'b1}}};
		end
		return r;
	endfunction

	logic [8:0]        restitution_q;
	logic [15:0]       radius_q;
	logic [RW-1:0]     two_r;
	logic [2*RW-1:0]   r2_q;

	item_t pipe_s [1:NS];
	item_t stg_d [1:NS];
	logic  vld_s [1:NS];
	logic  rdy [1:NS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restitution_q <= RESTIT_RESET;
			radius_q <= RADIUS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_RESTITUTION: restitution_q <= cfg_data[8:0];
				CFG_RADIUS: radius_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign two_r = ((RW'(radius_q) << LSH) >> RSH) << 1;

	always_ff @(posedge clk) begin
		r2_q <= two_r * two_r;
	end

	assign req_stall = !rdy[1];

	genvar g;
	generate
		for (g = 1; g <= NS; g++) begin : g_stage
			if (g == NS) begin : g_last
				assign rdy[g] = !vld_s[g] || !rsp_stall;
			end else begin : g_mid
				assign rdy[g] = !vld_s[g] || rdy[g+1];
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[g] <= 1'b0;
				end else if (rdy[g]) begin
					vld_s[g] <= (g == 1) ? req_valid : vld_s[(g == 1) ? 1 : g-1];
				end
			end

			always_ff @(posedge clk) begin
				if (rdy[g]) begin
					pipe_s[g] <= stg_d[g];
				end
			end

			if (g == S_IN) begin : g_in
				always_comb begin
					item_t it;
					logic signed [W:0] dx;
					logic signed [W:0] dy;
					logic [8:0] ee;
					it = '0;
					dx = {pos_bx[W-1], pos_bx} - {pos_ax[W-1], pos_ax};
					dy = {pos_by[W-1], pos_by} - {pos_ay[W-1], pos_ay};
					it.typ = req_type;
					it.act = both_active;
					it.vax = vel_ax;
					it.vay = vel_ay;
					it.vbx = vel_bx;
					it.vby = vel_by;
					it.ma = mass_a;
					it.mb = mass_b;
					it.msum = {1'b0, mass_a} + {1'b0, mass_b};
					ee = (req_type == REQ_ELASTIC) ? E_ONE :
						((restitution_q > E_ONE) ? E_ONE : restitution_q);
					it.k = 10'(E_ONE) + 10'(ee);
					it.inel = (req_type == REQ_INELASTIC) && (it.msum != '0);
					it.imp = (req_type == REQ_ELASTIC || req_type == REQ_RESTIT) &&
						(it.msum != '0);
					it.dxn = dx[W];
					it.dyn = dy[W];
					it.mx = dx[W] ? W'(-dx) : W'(dx);
					it.my = dy[W] ? W'(-dy) : W'(dy);
					it.dvx = {vel_ax[W-1], vel_ax} - {vel_bx[W-1], vel_bx};
					it.dvy = {vel_ay[W-1], vel_ay} - {vel_by[W-1], vel_by};
					it.iax = $signed({1'b0, mass_a}) * vel_ax;
					it.ibx = $signed({1'b0, mass_b}) * vel_bx;
					it.iay = $signed({1'b0, mass_a}) * vel_ay;
					it.iby = $signed({1'b0, mass_b}) * vel_by;
					stg_d[g] = it;
				end
			end else if (g == S_NORM) begin : g_norm
				always_comb begin
					item_t it;
					logic [NW-1:0] vxs;
					logic [NW-1:0] vys;
					logic [NW-1:0] vor;
					logic [CW-1:0] mxw;
					logic [CW-1:0] myw;
					logic [RW-1:0] mxc;
					logic [RW-1:0] myc;
					it = pipe_s[(g == 1) ? 1 : g-1];
					vxs = NW'(it.mx);
					vys = NW'(it.my);
					vor = vxs | vys;
					it.imp = it.imp && (vor != '0);
					for (int i = SHW - 1; i >= 0; i--) begin
						if ((vor >> (NW - (1 << i))) == '0) begin
							vor = vor << (1 << i);
							vxs = vxs << (1 << i);
							vys = vys << (1 << i);
						end
					end
					it.nxm = vxs[NW-1 -: 15];
					it.nym = vys[NW-1 -: 15];
					mxw = CW'(it.mx);
					myw = CW'(it.my);
					it.tlt = (mxw < CW'(two_r)) && (myw < CW'(two_r));
					mxc = mxw[RW-1:0];
					myc = myw[RW-1:0];
					it.tsx = mxc * mxc;
					it.tsy = myc * myc;
					it.isx = it.iax + it.ibx;
					it.isy = it.iay + it.iby;
					stg_d[g] = it;
				end
			end else if (g == S_SQR) begin : g_sqr
				always_comb begin
					item_t it;
					it = pipe_s[(g == 1) ? 1 : g-1];
					it.sqx = 32'(it.nxm) * 32'(it.nxm) + 32'(it.nym) * 32'(it.nym);
					it.srem = '0;
					it.root = '0;
					it.drx = 17'(it.nxm[14:1]);
					it.dry = 17'(it.nym[14:1]);
					it.qx = '0;
					it.qy = '0;
					it.touch = it.act && it.tlt &&
						(({1'b0, it.tsx} + {1'b0, it.tsy}) < {1'b0, r2_q});
					it.sgx = it.isx[W+17];
					it.sgy = it.isy[W+17];
					it.ima = it.isx[W+17] ? (W+18)'(-it.isx) : (W+18)'(it.isx);
					it.imb = it.isy[W+17] ? (W+18)'(-it.isy) : (W+18)'(it.isy);
					stg_d[g] = it;
				end
			end else if (g >= SQ0 && g < ND0) begin : g_sqrt
				always_comb begin
					item_t it;
					int j;
					logic [18:0] rem;
					logic [17:0] trial;
					it = pipe_s[(g == 1) ? 1 : g-1];
					rem = '0;
					trial = '0;
					for (int t = 0; t < SPS; t++) begin
						j = (g - SQ0) * SPS + t;
						if (j < SQRT_STEPS) begin
							rem = {it.srem[16:0], it.sqx[31 - 2*j -: 2]};
							trial = {it.root, 2'b01};
							if (rem >= 19'(trial)) begin
								it.srem = rem - 19'(trial);
								it.root = {it.root[14:0], 1'b1};
							end else begin
								it.srem = rem;
								it.root = {it.root[14:0], 1'b0};
							end
						end
					end
					stg_d[g] = it;
				end
			end else if (g >= ND0 && g < S_NSIGN) begin : g_ndiv
				always_comb begin
					item_t it;
					int j;
					logic [16:0] rx;
					logic [16:0] ry;
					it = pipe_s[(g == 1) ? 1 : g-1];
					rx = '0;
					ry = '0;
					for (int t = 0; t < SPS; t++) begin
						j = (g - ND0) * SPS + t;
						if (j < NDIV_STEPS) begin
							rx = {it.drx[15:0], (j == 0) ? it.nxm[0] : 1'b0};
							ry = {it.dry[15:0], (j == 0) ? it.nym[0] : 1'b0};
							if (rx >= {1'b0, it.root}) begin
								rx = rx - {1'b0, it.root};
								it.qx = {it.qx[13:0], 1'b1};
							end else begin
								it.qx = {it.qx[13:0], 1'b0};
							end
							if (ry >= {1'b0, it.root}) begin
								ry = ry - {1'b0, it.root};
								it.qy = {it.qy[13:0], 1'b1};
							end else begin
								it.qy = {it.qy[13:0], 1'b0};
							end
							it.drx = rx;
							it.dry = ry;
						end
					end
					stg_d[g] = it;
				end
			end else if (g == S_NSIGN) begin : g_nsign
				always_comb begin
					item_t it;
					it = pipe_s[(g == 1) ? 1 : g-1];
					it.nx = it.dxn ? 16'(-{1'b0, it.qx}) : 16'({1'b0, it.qx});
					it.ny = it.dyn ? 16'(-{1'b0, it.qy}) : 16'({1'b0, it.qy});
					stg_d[g] = it;
				end
			end else if (g == S_PROD) begin : g_prod
				always_comb begin
					item_t it;
					it = pipe_s[(g == 1) ? 1 : g-1];
					it.px = it.dvx * it.nx;
					it.py = it.dvy * it.ny;
					stg_d[g] = it;
				end
			end else if (g == S_P) begin : g_p
				always_comb begin
					item_t it;
					logic signed [W+17:0] p;
					it = pipe_s[(g == 1) ? 1 : g-1];
					p = (W+18)'(it.px) + (W+18)'(it.py);
					it.pos = !p[W+17] && (p != '0);
					it.vr = p[W+14:14];
					stg_d[g] = it;
				end
			end else if (g == S_X) begin : g_x
				always_comb begin
					item_t it;
					it = pipe_s[(g == 1) ? 1 : g-1];
					it.xk = it.k * it.vr;
					stg_d[g] = it;
				end
			end else if (g == S_NUM) begin : g_num
				always_comb begin
					item_t it;
					it = pipe_s[(g == 1) ? 1 : g-1];
					it.na = it.xk * it.mb;
					it.nb = it.xk * it.ma;
					stg_d[g] = it;
				end
			end else if (g == S_SEL) begin : g_sel
				always_comb begin
					item_t it;
					it = pipe_s[(g == 1) ? 1 : g-1];
					if (it.inel) begin
						it.da = NUMW'(it.ima);
						it.db = NUMW'(it.imb);
					end else begin
						it.da = NUMW'(it.na >> 8);
						it.db = NUMW'(it.nb >> 8);
					end
					it.ra = 18'(it.da >> QB);
					it.rb = 18'(it.db >> QB);
					it.qa = '0;
					it.qb = '0;
					stg_d[g] = it;
				end
			end else if (g >= JD0 && g < S_JP) begin : g_jdiv
				always_comb begin
					item_t it;
					int j;
					logic [17:0] ra;
					logic [17:0] rb;
					it = pipe_s[(g == 1) ? 1 : g-1];
					ra = '0;
					rb = '0;
					for (int t = 0; t < SPS; t++) begin
						j = (g - JD0) * SPS + t;
						if (j < QB) begin
							ra = {it.ra[16:0], it.da[QB-1-j]};
							rb = {it.rb[16:0], it.db[QB-1-j]};
							if (ra >= {1'b0, it.msum}) begin
								ra = ra - {1'b0, it.msum};
								it.qa = {it.qa[QB-2:0], 1'b1};
							end else begin
								it.qa = {it.qa[QB-2:0], 1'b0};
							end
							if (rb >= {1'b0, it.msum}) begin
								rb = rb - {1'b0, it.msum};
								it.qb = {it.qb[QB-2:0], 1'b1};
							end else begin
								it.qb = {it.qb[QB-2:0], 1'b0};
							end
							it.ra = ra;
							it.rb = rb;
						end
					end
					stg_d[g] = it;
				end
			end else if (g == S_JP) begin : g_jp
				always_comb begin
					item_t it;
					it = pipe_s[(g == 1) ? 1 : g-1];
					it.fx = it.sgx ? -$signed({1'b0, it.qa}) : $signed({1'b0, it.qa});
					it.fy = it.sgy ? -$signed({1'b0, it.qb}) : $signed({1'b0, it.qb});
					it.pax = $signed({1'b0, it.qa}) * it.nx;
					it.pay = $signed({1'b0, it.qa}) * it.ny;
					it.pbx = $signed({1'b0, it.qb}) * it.nx;
					it.pby = $signed({1'b0, it.qb}) * it.ny;
					stg_d[g] = it;
				end
			end else if (g == S_UPD) begin : g_upd
				always_comb begin
					item_t it;
					it = pipe_s[(g == 1) ? 1 : g-1];
					if (it.inel) begin
						it.rax = (W+6)'(it.fx);
						it.ray = (W+6)'(it.fy);
						it.rbx = (W+6)'(it.fx);
						it.rby = (W+6)'(it.fy);
					end else if (it.imp && it.pos) begin
						it.rax = (W+6)'(it.vax) - (W+6)'(trunc_q14(it.pax));
						it.ray = (W+6)'(it.vay) - (W+6)'(trunc_q14(it.pay));
						it.rbx = (W+6)'(it.vbx) + (W+6)'(trunc_q14(it.pbx));
						it.rby = (W+6)'(it.vby) + (W+6)'(trunc_q14(it.pby));
					end else begin
						it.rax = (W+6)'(it.vax);
						it.ray = (W+6)'(it.vay);
						it.rbx = (W+6)'(it.vbx);
						it.rby = (W+6)'(it.vby);
					end
					it.appl = it.inel || (it.imp && it.pos);
					it.stk = it.inel;
					stg_d[g] = it;
				end
			end else begin : g_out
				always_comb begin
					item_t it;
					it = pipe_s[(g == 1) ? 1 : g-1];
					it.oax = sat_v(it.rax);
					it.oay = sat_v(it.ray);
					it.obx = sat_v(it.rbx);
					it.oby = sat_v(it.rby);
					stg_d[g] = it;
				end
			end
		end
	endgenerate

	assign rsp_valid = vld_s[NS];
	assign new_vel_ax = pipe_s[NS].oax;
	assign new_vel_ay = pipe_s[NS].oay;
	assign new_vel_bx = pipe_s[NS].obx;
	assign new_vel_by = pipe_s[NS].oby;
	assign stuck = pipe_s[NS].stk;
	assign applied = pipe_s[NS].appl;
	assign touching = pipe_s[NS].touch;

endmodule

FILE: design/cpcr_checker.sv
module cpcr_checker import cpcr_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_stall,
	input logic                          rsp_valid,
	input logic                          rsp_stall,
	input logic signed [VALUE_WIDTH-1:0] new_vel_ax,
	input logic signed [VALUE_WIDTH-1:0] new_vel_ay,
	input logic signed [VALUE_WIDTH-1:0] new_vel_bx,
	input logic signed [VALUE_WIDTH-1:0] new_vel_by,
	input logic                          stuck,
	input logic                          applied
);

	// A held result keeps its item until it is taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(new_vel_ax) &&
		$stable(new_vel_by) && $stable(stuck) && $stable(applied))
		else $error("rsp item changed while stalled");

	// The input side only stalls when the full pipeline is blocked at the output.
	a_req_stall: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("req stalled without output back pressure");

	a_stuck_applied: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && stuck |-> applied)
		else $error("stuck item without applied");

	a_stuck_equal: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && stuck |-> new_vel_ax == new_vel_bx && new_vel_ay == new_vel_by)
		else $error("joined discs have different velocities");

	a_idle_req: assert property (@(posedge clk) disable iff (!arst_n)
		!req_valid && !rsp_valid |-> !req_stall)
		else $error("req stalled while pipeline output is empty");

endmodule

bind circle_pair_collision_resolver cpcr_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_cpcr_checker (.*);

FILE: test/circle_pair_collision_resolver_test.sv
module circle_pair_collision_resolver_test;
	timeunit 1ns;
	timeprecision 1ps;

	import cpcr_pkg::*;

	localparam int VW = VALUE_WIDTH_DEF;
	localparam int SETTLE_CYCLES = 60;
	localparam longint CYCLE_LIMIT = 600000;

	typedef logic signed [VW-1:0] value_t;

	typedef struct packed {
		logic [1:0] kind;
		value_t pax, pay, vax, vay, pbx, pby, vbx, vby;
		logic [15:0] ma, mb;
		logic active;
	} pair_t;

	typedef struct packed {
		value_t ax, ay, bx, by;
		logic stuck, applied, touching;
	} velocities_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [1:0] req_type = '0;
	value_t pos_ax = '0, pos_ay = '0, vel_ax = '0, vel_ay = '0;
	value_t pos_bx = '0, pos_by = '0, vel_bx = '0, vel_by = '0;
	logic [15:0] mass_a = '0, mass_b = '0;
	logic both_active = 1'b0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	value_t new_vel_ax, new_vel_ay, new_vel_bx, new_vel_by;
	logic stuck, applied, touching;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	circle_pair_collision_resolver i_dut (.*);

	always #1 clk = ~clk;

	logic [8:0] restitution_q = RESTIT_RESET;
	logic [15:0] radius_q = RADIUS_RESET;
	velocities_t expected_q[$];
	int mismatches = 0;
	longint cycles = 0;
	int burst_left = 0;
	bit no_gaps = 1'b0;
	int stall_mode = 0;
	int hold_off = 0;

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic value_t saturate(longint v);
		longint hi, lo;
		hi = (longint'(1) << (VW - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) v = hi;
		if (v < lo) v = lo;
		return value_t'(v);
	endfunction

	function automatic velocities_t resolve_pair(pair_t p);
		velocities_t res;
		longint vax, vay, vbx, vby, ma, mb, msum, dx, dy, nax, nay, nbx, nby;
		longint nx, ny, dot, vr, k, ja, jb;
		longint unsigned mx, my, m, two_r, len, e;
		vax = p.vax; vay = p.vay; vbx = p.vbx; vby = p.vby;
		ma = p.ma; mb = p.mb;
		msum = ma + mb;
		dx = longint'(p.pbx) - longint'(p.pax);
		dy = longint'(p.pby) - longint'(p.pay);
		mx = dx < 0 ? -dx : dx;
		my = dy < 0 ? -dy : dy;
		two_r = 2 * longint'(radius_q);
		nax = vax; nay = vay; nbx = vbx; nby = vby;
		res = '0;
		res.touching = p.active && mx < two_r && my < two_r && mx * mx + my * my < two_r * two_r;
		if (p.kind == REQ_INELASTIC && msum != 0) begin
			nax = (ma * vax + mb * vbx) / msum;
			nay = (ma * vay + mb * vby) / msum;
			nbx = nax;
			nby = nay;
			res.stuck = 1'b1;
			res.applied = 1'b1;
		end else if ((p.kind == REQ_ELASTIC || p.kind == REQ_RESTIT) && msum != 0
			&& (mx | my) != 0) begin
			m = mx > my ? mx : my;
			e = p.kind == REQ_ELASTIC ? E_ONE : (restitution_q > E_ONE ? E_ONE : restitution_q);
			while (m >= 32768) begin
				mx >>= 1; my >>= 1; m >>= 1;
			end
			while (m < 16384) begin
				mx <<= 1; my <<= 1; m <<= 1;
			end
			len = int_sqrt(mx * mx + my * my);
			nx = longint'((mx << NORM_SH) / len);
			ny = longint'((my << NORM_SH) / len);
			if (dx < 0) nx = -nx;
			if (dy < 0) ny = -ny;
			dot = (vax - vbx) * nx + (vay - vby) * ny;
			if (dot > 0) begin
				vr = dot / (longint'(1) << NORM_SH);
				k = 256 + longint'(e);
				ja = k * vr * mb / (256 * msum);
				jb = k * vr * ma / (256 * msum);
				nax = vax - ja * nx / (longint'(1) << NORM_SH);
				nay = vay - ja * ny / (longint'(1) << NORM_SH);
				nbx = vbx + jb * nx / (longint'(1) << NORM_SH);
				nby = vby + jb * ny / (longint'(1) << NORM_SH);
				res.applied = 1'b1;
			end
		end
		res.ax = saturate(nax);
		res.ay = saturate(nay);
		res.bx = saturate(nbx);
		res.by = saturate(nby);
		return res;
	endfunction

	task automatic send_pair(pair_t p);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = no_gaps ? 0 : $urandom_range(0, 6);
			repeat (gap) @(negedge clk);
		end
		burst_left--;
		req_valid = 1'b1;
		req_type = p.kind;
		pos_ax = p.pax; pos_ay = p.pay; vel_ax = p.vax; vel_ay = p.vay;
		pos_bx = p.pbx; pos_by = p.pby; vel_bx = p.vbx; vel_by = p.vby;
		mass_a = p.ma; mass_b = p.mb;
		both_active = p.active;
		do @(posedge clk); while (req_stall);
		expected_q.push_back(resolve_pair(p));
		@(negedge clk);
		req_valid = 1'b0;
	endtask

	task automatic write_register(logic [CFG_IW-1:0] idx, logic [15:0] data);
		wait (expected_q.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_RESTITUTION) restitution_q = data[8:0];
		else radius_q = data;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic value_t rand_value();
		return value_t'($urandom);
	endfunction

	function automatic value_t near(value_t base, int span);
		return value_t'(longint'(base) + $urandom_range(0, 2 * span) - span);
	endfunction

	function automatic pair_t random_pair();
		pair_t p;
		int span;
		p.kind = $urandom_range(0, 9) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
		p.active = $urandom_range(0, 3) != 0;
		p.ma = $urandom_range(0, 40) == 0 ? 16'($urandom_range(0, 1)) : 16'($urandom);
		p.mb = $urandom_range(0, 40) == 0 ? 16'($urandom_range(0, 1)) : 16'($urandom);
		if ($urandom_range(0, 4) == 0) begin
			p.pax = rand_value(); p.pay = rand_value(); p.vax = rand_value(); p.vay = rand_value();
			p.pbx = rand_value(); p.pby = rand_value(); p.vbx = rand_value(); p.vby = rand_value();
		end else begin
			span = 4 * radius_q + 16;
			p.pax = value_t'($urandom_range(0, 1 << 21)) - value_t'(1 << 20);
			p.pay = value_t'($urandom_range(0, 1 << 21)) - value_t'(1 << 20);
			p.pbx = near(p.pax, span);
			p.pby = near(p.pay, span);
			p.vax = near('0, 1 << ($urandom_range(4, 22)));
			p.vay = near('0, 1 << ($urandom_range(4, 22)));
			p.vbx = near('0, 1 << ($urandom_range(4, 22)));
			p.vby = near('0, 1 << ($urandom_range(4, 22)));
		end
		return p;
	endfunction

	task automatic test_directed();
		pair_t p;
		value_t vmax, vmin;
		vmax = {1'b0, {(VW - 1){1'b1}}};
		vmin = {1'b1, {(VW - 1){1'b0}}};
		for (int i = 0; i < 24; i++) begin
			p = '0;
			p.kind = 2'(i % 4);
			p.ma = 16'h0100;
			p.mb = 16'h0100;
			p.active = 1'b1;
			p.pbx = 24'sd1024;
			p.vax = 24'sd512;
			p.vbx = -24'sd512;
			case (i / 4)
				0: ;
				1: begin
					p.vax = -24'sd512;
					p.vbx = 24'sd512;
				end
				2: p.pbx = '0;
				3: begin
					p.ma = '0;
					p.mb = '0;
				end
				4: begin
					p.pax = vmin; p.pay = vmin; p.pbx = vmax; p.pby = vmax;
					p.vax = vmax; p.vay = vmax; p.vbx = vmin; p.vby = vmin;
					p.ma = 16'hFFFF; p.mb = 16'hFFFF;
				end
				default: begin
					p.pax = vmax; p.pay = vmax; p.pbx = vmin; p.pby = vmin;
					p.vax = vmin; p.vay = vmin; p.vbx = vmax; p.vby = vmax;
					p.ma = 16'h0001; p.mb = 16'hFFFF; p.active = 1'b0;
				end
			endcase
			send_pair(p);
		end
	endtask

	task automatic test_registers();
		logic [15:0] restitutions[5] = '{16'd0, 16'd256, 16'd511, 16'd257, 16'd77};
		logic [15:0] radii[5] = '{16'd0, 16'hFFFF, 16'd1, 16'd700, 16'd2560};
		for (int s = 0; s < 5; s++) begin
			write_register(CFG_RESTITUTION, restitutions[s]);
			write_register(CFG_RADIUS, radii[s]);
			repeat (60) send_pair(random_pair());
		end
	endtask

	task automatic test_random();
		for (int i = 0; i < 1400; i++) begin
			if (i % 200 == 0) begin
				no_gaps = $urandom_range(0, 2) == 0;
				stall_mode = $urandom_range(0, 3);
			end
			send_pair(random_pair());
		end
		no_gaps = 1'b0;
	endtask

	task automatic test_backpressure();
		no_gaps = 1'b1;
		stall_mode = 0;
		hold_off = 200;
		repeat (150) send_pair(random_pair());
		no_gaps = 1'b0;
	endtask

	always @(negedge clk) begin
		if (hold_off > 0) begin
			rsp_stall = 1'b1;
			hold_off--;
		end else begin
			case (stall_mode)
				1: rsp_stall = $urandom_range(0, 2) == 0;
				2: rsp_stall = (cycles % 7) < 3;
				3: rsp_stall = $urandom_range(0, 9) != 0;
				default: rsp_stall = 1'b0;
			endcase
		end
	end

	always @(posedge clk) begin
		velocities_t exp_v;
		if (rsp_valid && !rsp_stall) begin
			if (expected_q.size() == 0) begin
				$error("result with no item outstanding");
				mismatches++;
			end else begin
				exp_v = expected_q.pop_front();
				if (new_vel_ax !== exp_v.ax) begin
					$error("new_vel_ax expected %0d actual %0d", exp_v.ax, new_vel_ax);
					mismatches++;
				end
				if (new_vel_ay !== exp_v.ay) begin
					$error("new_vel_ay expected %0d actual %0d", exp_v.ay, new_vel_ay);
					mismatches++;
				end
				if (new_vel_bx !== exp_v.bx) begin
					$error("new_vel_bx expected %0d actual %0d", exp_v.bx, new_vel_bx);
					mismatches++;
				end
				if (new_vel_by !== exp_v.by) begin
					$error("new_vel_by expected %0d actual %0d", exp_v.by, new_vel_by);
					mismatches++;
				end
				if (stuck !== exp_v.stuck) begin
					$error("stuck expected %0d actual %0d", exp_v.stuck, stuck);
					mismatches++;
				end
				if (applied !== exp_v.applied) begin
					$error("applied expected %0d actual %0d", exp_v.applied, applied);
					mismatches++;
				end
				if (touching !== exp_v.touching) begin
					$error("touching expected %0d actual %0d", exp_v.touching, touching);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_backpressure();
		test_registers();
		test_random();
		wait (expected_q.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
